/* hdl/mrtu_pkg.sv */
// ---------------------------------------------------------------------------
// Modbus RTU receiver package
// Shared constants, register indexes and the per-item result type.
// ---------------------------------------------------------------------------
package mrtu_pkg;

    localparam int BUFFER_BYTES = 256;
    localparam int COUNT_W      = $clog2(BUFFER_BYTES + 1);
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_INDEX_W  = 1;

    localparam logic [COUNT_W-1:0] BUFFER_LIMIT    = COUNT_W'(BUFFER_BYTES);
    localparam logic [COUNT_W-1:0] MIN_FRAME_BYTES = COUNT_W'(3);

    localparam logic [7:0]  BROADCAST_ADDR = 8'h00;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'hA001;
    localparam logic [15:0] IDLE_MAX       = 16'hFFFF;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_OWN_ADDRESS   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_TICKS = 1'd1;

    localparam logic [7:0]  OWN_ADDRESS_RST   = 8'd1;
    localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd1000;

    typedef struct packed {
        logic       byte_kept;
        logic [7:0] byte_index;
        logic [7:0] data_byte;
        logic       frame_done;
        logic [8:0] frame_length;
        logic       frame_dropped;
    } mrtu_result_t;

endpackage

/* hdl/mrtu_crc8.sv */
// ---------------------------------------------------------------------------
// Modbus CRC-16 byte update
// Folds one byte into the running CRC, reflected polynomial, LSB first.
// ---------------------------------------------------------------------------
module mrtu_crc8 (
    input  logic [15:0] crc_in,
    input  logic [7:0]  data_in,
    output logic [15:0] crc_out
);

    always_comb
    begin
        logic [15:0] c;
        c = crc_in ^ {8'h00, data_in};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ mrtu_pkg::CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        crc_out = c;
    end

endmodule

/* hdl/mrtu_frame_ctrl.sv */
// ---------------------------------------------------------------------------
// Modbus RTU frame control
// Frame state (CRC, byte count, address, idle timer) and per-item result.
// ---------------------------------------------------------------------------
module mrtu_frame_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic                  kind,
    input  logic [7:0]            rx_byte,
    input  logic [7:0]            own_address,
    input  logic [15:0]           timeout_ticks,
    output mrtu_pkg::mrtu_result_t result
);

    logic [15:0]                  crc_reg, crc_next;
    logic [mrtu_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [7:0]                   addr_reg, addr_next;
    logic [15:0]                  idle_reg, idle_next;

    logic [15:0]                  crc_upd;
    logic [mrtu_pkg::COUNT_W-1:0] count_inc;
    logic [15:0]                  idle_inc;
    logic [7:0]                   addr_eff;
    logic                         keep;

    mrtu_crc8 u_crc (
        .crc_in  (crc_reg),
        .data_in (rx_byte),
        .crc_out (crc_upd)
    );

    assign addr_eff  = (count_reg == '0) ? rx_byte : addr_reg;
    assign keep      = (kind == mrtu_pkg::KIND_BYTE)
                       && (addr_eff == own_address || addr_eff == mrtu_pkg::BROADCAST_ADDR)
                       && (count_reg < mrtu_pkg::BUFFER_LIMIT);
    assign count_inc = count_reg + 1'b1;
    assign idle_inc  = (idle_reg == mrtu_pkg::IDLE_MAX) ? idle_reg : idle_reg + 16'd1;

    always_comb
    begin
        crc_next   = crc_reg;
        count_next = count_reg;
        addr_next  = addr_reg;
        idle_next  = idle_reg;
        result     = '0;
        if (kind == mrtu_pkg::KIND_BYTE)
        begin
            addr_next = addr_eff;
            if (keep)
            begin
                result.byte_kept  = 1'b1;
                result.byte_index = 8'(count_reg);
                result.data_byte  = rx_byte;
                idle_next         = '0;
                if (crc_upd == 16'h0000 && count_inc > mrtu_pkg::MIN_FRAME_BYTES)
                begin
                    result.frame_done   = 1'b1;
                    result.frame_length = 9'(count_inc);
                    crc_next            = mrtu_pkg::CRC_INIT;
                    count_next          = '0;
                end
                else
                begin
                    crc_next   = crc_upd;
                    count_next = count_inc;
                end
            end
        end
        else if (count_reg != '0)
        begin
            if (idle_inc >= timeout_ticks)
            begin
                result.frame_dropped = 1'b1;
                crc_next             = mrtu_pkg::CRC_INIT;
                count_next           = '0;
                idle_next            = '0;
            end
            else
            begin
                idle_next = idle_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= mrtu_pkg::CRC_INIT;
            count_reg <= '0;
            addr_reg  <= '0;
            idle_reg  <= '0;
        end
        else if (step)
        begin
            crc_reg   <= crc_next;
            count_reg <= count_next;
            addr_reg  <= addr_next;
            idle_reg  <= idle_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= mrtu_pkg::BUFFER_LIMIT)
        else $error("byte count above buffer size");

    a_done_restart: assert property (@(posedge clk) disable iff (!rst_n)
        step && result.frame_done |=> count_reg == '0 && crc_reg == mrtu_pkg::CRC_INIT)
        else $error("frame not restarted after completion");

    a_drop_restart: assert property (@(posedge clk) disable iff (!rst_n)
        step && result.frame_dropped |=> count_reg == '0 && idle_reg == '0)
        else $error("frame not cleared after timeout");

    a_kept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step && result.byte_kept |=> idle_reg == '0)
        else $error("idle timer not cleared by kept byte");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(crc_reg) && $stable(count_reg) && $stable(idle_reg))
        else $error("frame state changed without a transfer");

endmodule

/* hdl/modbus_rtu_frame_receiver.sv */
// ---------------------------------------------------------------------------
// Modbus RTU frame receiver
// Byte/tick stream in, one result per item out, with CRC check and timeout.
// ---------------------------------------------------------------------------
// Takes one item (received byte or time tick) per clock while in_ready is
// high. Each item is evaluated in the cycle it is transferred in: the CRC-16
// byte update and the count/idle compares sit between the frame state
// registers and the result register, so the result appears on the output in
// the cycle after the input transfer. in_ready stays high while the result
// register is empty or being drained, so back-to-back items run at one per
// clock under no output stall. Configuration writes take effect on the next
// clock and are meant for idle periods only.
module modbus_rtu_frame_receiver (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [mrtu_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mrtu_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               kind,
    input  logic [7:0]                         rx_byte,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               byte_kept,
    output logic [7:0]                         byte_index,
    output logic [7:0]                         data_byte,
    output logic                               frame_done,
    output logic [8:0]                         frame_length,
    output logic                               frame_dropped
);

    logic [7:0]             own_address_reg;
    logic [15:0]            timeout_ticks_reg;
    logic                   out_valid_reg;
    mrtu_pkg::mrtu_result_t result_reg;
    mrtu_pkg::mrtu_result_t result_next;
    logic                   in_xfer;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_xfer  = in_valid && in_ready;

    mrtu_frame_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (in_xfer),
        .kind          (kind),
        .rx_byte       (rx_byte),
        .own_address   (own_address_reg),
        .timeout_ticks (timeout_ticks_reg),
        .result        (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_address_reg   <= mrtu_pkg::OWN_ADDRESS_RST;
            timeout_ticks_reg <= mrtu_pkg::TIMEOUT_TICKS_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                mrtu_pkg::REG_OWN_ADDRESS:   own_address_reg   <= cfg_data[7:0];
                mrtu_pkg::REG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign byte_kept     = result_reg.byte_kept;
    assign byte_index    = result_reg.byte_index;
    assign data_byte     = result_reg.data_byte;
    assign frame_done    = result_reg.frame_done;
    assign frame_length  = result_reg.frame_length;
    assign frame_dropped = result_reg.frame_dropped;

endmodule
